// ----- sv/bb3_pkg.sv -----
package bb3_pkg;

    localparam int ROW_W = 12;
    localparam int X_W = 10;
    localparam int Y_W = 11;
    localparam int CFG_W = 12;
    localparam int FW_W = 11;
    localparam int FH_W = 12;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 11'd800;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd600;

    localparam logic REG_FRAME_WIDTH = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [ROW_W-1:0] ROW_SAT = 12'hFFF;

    localparam logic [7:0] ALPHA = 8'hFF;

    // floor(s / 9) == (s * 7282) >> 16 for s <= 2295
    localparam int SUM_W = 12;
    localparam int RSUM_W = 10;
    localparam int DIV9_W = 13;
    localparam logic [DIV9_W-1:0] DIV9_MUL = 13'd7282;
    localparam int DIV9_SHIFT = 16;
    localparam int PROD_W = SUM_W + DIV9_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bb3_pix_t;

    typedef bb3_pix_t bb3_win_t [3][3];

    typedef struct packed {
        logic           emit;
        logic           last;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           en_top;
        logic           en_bot;
        logic           en_left;
        logic           en_right;
    } bb3_tag_t;

    typedef struct packed {
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } bb3_res_t;

endpackage

// ----- sv/bb3_ram.sv -----
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/bb3_line_buf.sv -----
module bb3_line_buf
    import bb3_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     acc,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  bb3_pix_t                 pix,
    input  bb3_tag_t                 tag,
    output logic                     win_valid,
    output bb3_tag_t                 win_tag,
    output bb3_win_t                 win
);

    localparam int AW = $clog2(DEPTH);

    logic            s1_valid_reg;
    logic [AW-1:0]   s1_addr_reg;
    bb3_pix_t        s1_pix_reg;
    bb3_tag_t        s1_tag_reg;
    logic            fwd_reg;
    logic            fwd_next;
    bb3_pix_t        fwd_data_reg;
    logic [23:0]     mid_rd;
    logic [23:0]     top_rd;
    bb3_pix_t        top_eff;
    logic            s2_valid_reg;
    bb3_tag_t        s2_tag_reg;
    bb3_win_t        win_reg;

    bb3_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_mid_ram (
        .aclk  (aclk),
        .we    (acc),
        .waddr (addr),
        .wdata (pix),
        .re    (acc),
        .raddr (addr),
        .rdata (mid_rd)
    );

    bb3_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_top_ram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (mid_rd),
        .re    (acc),
        .raddr (addr),
        .rdata (top_rd)
    );

    assign fwd_next = acc && s1_valid_reg && (addr == s1_addr_reg);
    assign top_eff  = fwd_reg ? fwd_data_reg : bb3_pix_t'(top_rd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= acc;
            fwd_reg      <= fwd_next;
            s2_valid_reg <= s1_valid_reg && s1_tag_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_addr_reg <= addr;
            s1_pix_reg  <= pix;
            s1_tag_reg  <= tag;
        end
        fwd_data_reg <= bb3_pix_t'(mid_rd);
        if (s1_valid_reg) begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (s1_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_eff;
            win_reg[1][2] <= bb3_pix_t'(mid_rd);
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    assign win_valid = s2_valid_reg;
    assign win_tag   = s2_tag_reg;
    assign win       = win_reg;

endmodule

// ----- sv/bb3_sum.sv -----
module bb3_sum
    import bb3_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  bb3_tag_t in_tag,
    input  bb3_win_t win,
    output logic     out_valid,
    output bb3_res_t out_res
);

    logic [RSUM_W-1:0] rs_next [3][3];
    logic [RSUM_W-1:0] rs_reg  [3][3];
    logic [SUM_W-1:0]  tot_next [3];
    logic [SUM_W-1:0]  tot_reg  [3];
    logic [PROD_W-1:0] prod [3];
    logic              s3_valid_reg;
    logic              s4_valid_reg;
    logic              s5_valid_reg;
    bb3_tag_t          s3_tag_reg;
    bb3_tag_t          s4_tag_reg;
    bb3_res_t          res_reg;
    logic              row_en [3];
    logic              col_en [3];
    bb3_pix_t          p;

    always_comb begin
        row_en[0] = in_tag.en_top;
        row_en[1] = 1'b1;
        row_en[2] = in_tag.en_bot;
        col_en[0] = in_tag.en_left;
        col_en[1] = 1'b1;
        col_en[2] = in_tag.en_right;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                rs_next[i][k] = '0;
            end
            for (int j = 0; j < 3; j++) begin
                p = (row_en[i] && col_en[j]) ? win[i][j] : '0;
                rs_next[i][0] = rs_next[i][0] + RSUM_W'(p.red);
                rs_next[i][1] = rs_next[i][1] + RSUM_W'(p.green);
                rs_next[i][2] = rs_next[i][2] + RSUM_W'(p.blue);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tot_next[k] = SUM_W'(rs_reg[0][k]) + SUM_W'(rs_reg[1][k]) + SUM_W'(rs_reg[2][k]);
            prod[k]     = PROD_W'(tot_reg[k]) * PROD_W'(DIV9_MUL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            rs_reg     <= rs_next;
            s3_tag_reg <= in_tag;
        end
        if (s3_valid_reg) begin
            tot_reg    <= tot_next;
            s4_tag_reg <= s3_tag_reg;
        end
        if (s4_valid_reg) begin
            res_reg.red   <= prod[0][DIV9_SHIFT +: 8];
            res_reg.green <= prod[1][DIV9_SHIFT +: 8];
            res_reg.blue  <= prod[2][DIV9_SHIFT +: 8];
            res_reg.x     <= s4_tag_reg.x;
            res_reg.y     <= s4_tag_reg.y;
            res_reg.last  <= s4_tag_reg.last;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- sv/bb3_out_fifo.sv -----
module bb3_out_fifo
    import bb3_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  bb3_res_t push_data,
    input  logic     pop,
    output logic     valid,
    output bb3_res_t head
);

    bb3_res_t              mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_pop;

    assign valid  = (count_reg != '0);
    assign head   = mem[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/box_blur_3x3_rgb_top.sv -----
// channel | ports      | tdata (low bit first)                          | tuser | tlast
// input   | s_axis_*   | in_red, in_green, in_blue                      | kind  | -
// result  | m_axis_*   | out_red, out_green, out_blue, out_word, out_x, | -     | last_of_frame
//         |            | out_y, 3 zero bits                             |       |
// config  | cfg_*      | cfg_addr 0 frame_width, 1 frame_height         |       |
//
// One pixel per clock, back to back, while s_axis_tready is high. m_axis_tvalid rises
// after the triggering transaction passes memory read on the accepting edge, then window,
// row sums, total, divide by nine and queue write, each a registered step.
// Reset clears counters, window and result queue; line memories hold stale data.
// Input is taken while fewer than eight results are reserved in the output queue.
// A config write restarts the frame position.
module box_blur_3x3_rgb_top
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // in_red, in_green, in_blue
    input  logic             s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // out_red, out_green, out_blue, out_word,
                                             // out_x, out_y
    output logic             m_axis_tlast,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > FW_W) ? WW : FW_W;
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int HCW = (HW > FH_W) ? HW : FH_W;

    logic [FW_W-1:0]       width_reg;
    logic [FH_W-1:0]       height_reg;
    logic [COL_W-1:0]      in_col_reg;
    logic [COL_W-1:0]      in_col_next;
    logic [ROW_W-1:0]      in_row_reg;
    logic [ROW_W-1:0]      in_row_next;
    logic [COL_W-1:0]      out_col_reg;
    logic [COL_W-1:0]      out_col_next;
    logic [ROW_W-1:0]      out_row_reg;
    logic [ROW_W-1:0]      out_row_next;
    logic [FIFO_CNT_W-1:0] occ_reg;
    logic [FIFO_CNT_W-1:0] occ_next;

    logic [CW-1:0]  fw_ext;
    logic [CW-1:0]  eff_w;
    logic [HCW-1:0] fh_ext;
    logic [HCW-1:0] eff_h;
    logic           s_acc;
    logic           m_acc;
    logic           emit;
    logic           in_row_end;
    logic           x_end;
    logic           y_end;
    logic           frame_done;
    bb3_pix_t       pix;
    bb3_tag_t       tag;
    logic           win_valid;
    bb3_tag_t       win_tag;
    bb3_win_t       win;
    logic           res_valid;
    bb3_res_t       res;
    bb3_res_t       head;

    always_comb begin
        fw_ext = CW'(width_reg);
        if (fw_ext < CW'(3)) begin
            eff_w = CW'(3);
        end else if (fw_ext > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        fh_ext = HCW'(height_reg);
        if (fh_ext < HCW'(1)) begin
            eff_h = HCW'(1);
        end else if (fh_ext > HCW'(MAX_HEIGHT)) begin
            eff_h = HCW'(MAX_HEIGHT);
        end else begin
            eff_h = fh_ext;
        end
    end

    assign s_axis_tready = (occ_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_comb begin
        emit = (in_row_reg >= ROW_W'(2))
            || ((in_row_reg == ROW_W'(1)) && (in_col_reg >= COL_W'(1)));
        in_row_end = (CW'(in_col_reg) + CW'(1)) >= eff_w;
        x_end = (CW'(out_col_reg) + CW'(1)) >= eff_w;
        y_end = (HCW'(out_row_reg) + HCW'(1)) >= eff_h;
        frame_done = emit && x_end && y_end;

        if ((s_axis_tuser == KIND_PIXEL) && (HCW'(in_row_reg) < eff_h)) begin
            pix.red   = s_axis_tdata[7:0];
            pix.green = s_axis_tdata[15:8];
            pix.blue  = s_axis_tdata[23:16];
        end else begin
            pix = '0;
        end

        tag.emit     = emit;
        tag.last     = x_end && y_end;
        tag.x        = X_W'(out_col_reg);
        tag.y        = Y_W'(out_row_reg);
        tag.en_top   = (out_row_reg != '0);
        tag.en_bot   = !y_end;
        tag.en_left  = (out_col_reg != '0);
        tag.en_right = !x_end;
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s_acc) begin
            if (in_row_end) begin
                in_col_next = '0;
                if (in_row_reg < ROW_SAT) begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (frame_done) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (emit) begin
                if (x_end) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb begin
        occ_next = occ_reg;
        if ((s_acc && emit) && !m_acc) begin
            occ_next = occ_reg + FIFO_CNT_W'(1);
        end else if (!(s_acc && emit) && m_acc) begin
            occ_next = occ_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= FRAME_WIDTH_RESET;
            height_reg  <= FRAME_HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            occ_reg     <= '0;
        end else begin
            occ_reg <= occ_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH: begin
                        width_reg <= cfg_wdata[FW_W-1:0];
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg <= cfg_wdata[FH_W-1:0];
                    end
                    default: begin
                    end
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    bb3_line_buf #(.DEPTH(MAX_WIDTH)) u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc       (s_acc),
        .addr      (in_col_reg),
        .pix       (pix),
        .tag       (tag),
        .win_valid (win_valid),
        .win_tag   (win_tag),
        .win       (win)
    );

    bb3_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_tag    (win_tag),
        .win       (win),
        .out_valid (res_valid),
        .out_res   (res)
    );

    bb3_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_axis_tready),
        .valid     (m_axis_tvalid),
        .head      (head)
    );

    assign m_axis_tdata = {3'b000, head.y, head.x,
                           head.red, head.green, head.blue, ALPHA,
                           head.blue, head.green, head.red};
    assign m_axis_tlast = head.last;

endmodule
